[rtl/core/bbra_pkg.sv]
// Package for the bump/bitmap record allocator: codes, states, field widths
// and default sizes. Depends on nothing; every module in rtl/core imports it.
`timescale 1ns / 1ps

package bbra_pkg;

    localparam int DEF_MAX_RECORDS  = 32768;
    localparam int DEF_MAX_PER_HOST = 4096;

    localparam int OFFSET_W  = 48;
    localparam int BASE_W    = 40;
    localparam int HOST_W    = 3;
    localparam int RPH_W     = 13;
    localparam int TOTAL_W   = 16;
    localparam int RBYTES_W  = 13;
    localparam int HARV_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_STEPS = OFFSET_W;
    localparam int STEP_W    = $clog2(DIV_STEPS + 1);

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_FREE    = 2'd1;
    localparam logic [1:0] OP_RECLAIM = 2'd2;
    localparam logic [1:0] OP_UNUSED  = 2'd3;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOST_INDEX   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECS_PER_HST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_RECS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORD_BYTES = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RECORDS_BASE = 3'd4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SEG_MUL,
        ST_DISPATCH,
        ST_POP,
        ST_POP_DATA,
        ST_OFF_G,
        ST_OFF_MUL,
        ST_OFF_ADD,
        ST_DIV,
        ST_FREE_CHK,
        ST_RC_ISSUE,
        ST_RC_CHECK,
        ST_DONE
    } state_t;

endpackage

[rtl/core/bbra_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on bbra_pkg only by house convention; no reset on the array.
`timescale 1ns / 1ps

module bbra_ram
    import bbra_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/bump_bitmap_record_allocator.sv]
// Top level of the record allocator: sequencer, shared multiplier, divider
// and the free-stack and freed-bitmap memories. Depends on bbra_pkg, bbra_ram.
`timescale 1ns / 1ps

// Usage
// Input beats (in_valid/in_stall) carry an opcode and a free offset; each
// beat produces exactly one result beat (out_valid/out_stall) carrying the
// allocated offset, a status code and the reclaimed count. The block works
// on one beat at a time and holds in_stall high while it does.
// Steps of a beat: the segment base product and a dispatch; then for an
// allocate a free-stack pop and read, or a bump of the cursor, and then
// the record index, its product and the offset; for a free a 48-step
// restoring divide, one quotient bit per cycle, and a bitmap check. A free
// rejected before the divide and the unused opcode 3 go straight to the
// result. A reclaim pass reads, then checks, each segment record's bitmap
// bit, skipping one past the bitmap; an exhausted segment on allocate adds
// a full reclaim pass. The next beat is taken the cycle after a result loads.
// One multiplier is shared between the segment base product and the
// record offset product.
// After reset the freed bitmap is swept to zero, one bit per cycle, over
// all MAX_RECORDS bits; no input beat is taken meanwhile, while
// configuration writes are taken at all times (cfg_ready is tied high).
// The finished result sits in an output register; a new input beat can be
// taken while it waits, and the next result waits until out_stall drops.
module bump_bitmap_record_allocator
    import bbra_pkg::*;
#(
    parameter int MAX_RECORDS  = DEF_MAX_RECORDS,
    parameter int MAX_PER_HOST = DEF_MAX_PER_HOST
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [1:0]            opcode,
    input  logic [OFFSET_W-1:0]   free_offset,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OFFSET_W-1:0]   alloc_offset,
    output logic [1:0]            status,
    output logic [HARV_W-1:0]     harvested,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [BASE_W-1:0]     cfg_data
);

    // Count width holds 0..MAX_PER_HOST, stack index width addresses entries.
    localparam int CW = $clog2(MAX_PER_HOST + 1);
    localparam int SW = (MAX_PER_HOST > 1) ? $clog2(MAX_PER_HOST) : 1;
    localparam int BW = $clog2(MAX_RECORDS);
    localparam int GW = HOST_W + CW;
    localparam int MW = (CW > RBYTES_W) ? CW : RBYTES_W;
    localparam int PW = GW + MW;

    state_t state_reg, state_next;

    logic [HOST_W-1:0]   host_reg;
    logic [RPH_W-1:0]    rph_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [RBYTES_W-1:0] rbytes_reg;
    logic [BASE_W-1:0]   base_reg;

    logic [CW-1:0]       cursor_reg, cursor_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       harv_reg, harv_next;
    logic                after_alloc_reg, after_alloc_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [BW-1:0]       clr_reg, clr_next;
    logic                out_valid_reg, out_valid_next;

    logic [1:0]          op_reg, op_next;
    logic [OFFSET_W-1:0] off_reg, off_next;
    logic [GW-1:0]       gbase_reg, gbase_next;
    logic [SW-1:0]       local_reg, local_next;
    logic [GW-1:0]       g_reg, g_next;
    logic [PW-1:0]       prod_reg, prod_next;
    logic [OFFSET_W-1:0] res_off_reg, res_off_next;
    logic [1:0]          status_reg, status_next;
    logic [RBYTES_W-1:0] rem_reg, rem_next;
    logic [OFFSET_W-1:0] dq_reg, dq_next;
    logic [OFFSET_W-1:0] out_off_reg, out_off_next;
    logic [1:0]          out_stat_reg, out_stat_next;
    logic [CW-1:0]       out_harv_reg, out_harv_next;

    logic [GW-1:0]       mul_a;
    logic [MW-1:0]       mul_b;
    logic [PW-1:0]       mul_p;

    logic [31:0]         rph32;
    logic [31:0]         seg32;
    logic [CW-1:0]       seg_n;
    logic [GW-1:0]       g_rc;
    logic                g_rc_ok;
    logic [RBYTES_W:0]   div_trial;
    logic                div_ge;

    logic                st_we;
    logic [SW-1:0]       st_waddr, st_raddr;
    logic [SW-1:0]       st_wdata, st_rdata;
    logic                bm_we;
    logic [BW-1:0]       bm_waddr, bm_raddr;
    logic [0:0]          bm_wdata, bm_rdata;

    logic in_accept;
    logic out_accept;

    assign cfg_ready  = 1'b1;
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;

    assign out_valid    = out_valid_reg;
    assign alloc_offset = out_off_reg;
    assign status       = out_stat_reg;
    assign harvested    = HARV_W'(out_harv_reg);

    // Segment size is the register limited to the stack depth.
    assign rph32 = 32'(rph_reg);
    assign seg32 = (rph32 > 32'(MAX_PER_HOST)) ? 32'(MAX_PER_HOST) : rph32;
    assign seg_n = CW'(seg32);

    assign g_rc    = gbase_reg + GW'(idx_reg);
    assign g_rc_ok = (32'(g_rc) < 32'(MAX_RECORDS));

    assign mul_p = PW'(mul_a) * PW'(mul_b);

    assign div_trial = {rem_reg, dq_reg[OFFSET_W-1]};
    assign div_ge    = (div_trial >= {1'b0, rbytes_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_reg   <= '0;
            rph_reg    <= RPH_W'(4096);
            total_reg  <= TOTAL_W'(32768);
            rbytes_reg <= RBYTES_W'(16);
            base_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_HOST_INDEX:   host_reg   <= cfg_data[HOST_W-1:0];
                CFG_RECS_PER_HST: rph_reg    <= cfg_data[RPH_W-1:0];
                CFG_TOTAL_RECS:   total_reg  <= cfg_data[TOTAL_W-1:0];
                CFG_RECORD_BYTES: rbytes_reg <= cfg_data[RBYTES_W-1:0];
                CFG_RECORDS_BASE: base_reg   <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cursor_reg      <= '0;
            cnt_reg         <= '0;
            idx_reg         <= '0;
            harv_reg        <= '0;
            after_alloc_reg <= 1'b0;
            step_reg        <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            cnt_reg         <= cnt_next;
            idx_reg         <= idx_next;
            harv_reg        <= harv_next;
            after_alloc_reg <= after_alloc_next;
            step_reg        <= step_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        off_reg      <= off_next;
        gbase_reg    <= gbase_next;
        local_reg    <= local_next;
        g_reg        <= g_next;
        prod_reg     <= prod_next;
        res_off_reg  <= res_off_next;
        status_reg   <= status_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        out_off_reg  <= out_off_next;
        out_stat_reg <= out_stat_next;
        out_harv_reg <= out_harv_next;
    end

    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        cnt_next         = cnt_reg;
        idx_next         = idx_reg;
        harv_next        = harv_reg;
        after_alloc_next = after_alloc_reg;
        step_next        = step_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg;
        op_next          = op_reg;
        off_next         = off_reg;
        gbase_next       = gbase_reg;
        local_next       = local_reg;
        g_next           = g_reg;
        prod_next        = prod_reg;
        res_off_next     = res_off_reg;
        status_next      = status_reg;
        rem_next         = rem_reg;
        dq_next          = dq_reg;
        out_off_next     = out_off_reg;
        out_stat_next    = out_stat_reg;
        out_harv_next    = out_harv_reg;

        mul_a    = GW'(host_reg);
        mul_b    = MW'(seg_n);
        st_we    = 1'b0;
        st_waddr = SW'(cnt_reg);
        st_wdata = SW'(idx_reg);
        st_raddr = SW'(cnt_reg - CW'(1));
        bm_we    = 1'b0;
        bm_waddr = BW'(g_rc);
        bm_wdata = 1'b0;
        bm_raddr = BW'(g_rc);

        if (out_accept)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                clr_next = clr_reg + BW'(1);
                if (clr_reg == BW'(MAX_RECORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    op_next          = opcode;
                    off_next         = free_offset;
                    res_off_next     = '0;
                    status_next      = STAT_DONE;
                    harv_next        = '0;
                    after_alloc_next = 1'b0;
                    state_next       = ST_SEG_MUL;
                end
            end

            ST_SEG_MUL:
            begin
                gbase_next = GW'(mul_p);
                state_next = ST_DISPATCH;
            end

            ST_DISPATCH:
            begin
                case (op_reg)
                    OP_ALLOC:
                    begin
                        if (cnt_reg != '0)
                        begin
                            state_next = ST_POP;
                        end
                        else if (cursor_reg < seg_n)
                        begin
                            local_next  = SW'(cursor_reg);
                            cursor_next = cursor_reg + CW'(1);
                            state_next  = ST_OFF_G;
                        end
                        else
                        begin
                            cursor_next      = seg_n;
                            after_alloc_next = 1'b1;
                            idx_next         = '0;
                            state_next       = ST_RC_ISSUE;
                        end
                    end
                    OP_FREE:
                    begin
                        if (off_reg < OFFSET_W'(base_reg) || rbytes_reg == '0)
                        begin
                            status_next = STAT_BADFREE;
                            state_next  = ST_DONE;
                        end
                        else
                        begin
                            dq_next    = off_reg - OFFSET_W'(base_reg);
                            rem_next   = '0;
                            step_next  = STEP_W'(DIV_STEPS);
                            state_next = ST_DIV;
                        end
                    end
                    OP_RECLAIM:
                    begin
                        idx_next   = '0;
                        state_next = ST_RC_ISSUE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_POP:
            begin
                cnt_next   = cnt_reg - CW'(1);
                state_next = ST_POP_DATA;
            end

            ST_POP_DATA:
            begin
                local_next = st_rdata;
                state_next = ST_OFF_G;
            end

            ST_OFF_G:
            begin
                g_next     = gbase_reg + GW'(local_reg);
                state_next = ST_OFF_MUL;
            end

            ST_OFF_MUL:
            begin
                mul_a      = g_reg;
                mul_b      = MW'(rbytes_reg);
                prod_next  = mul_p;
                state_next = ST_OFF_ADD;
            end

            ST_OFF_ADD:
            begin
                res_off_next = OFFSET_W'(base_reg) + OFFSET_W'(prod_reg);
                state_next   = ST_DONE;
            end

            ST_DIV:
            begin
                rem_next  = div_ge ? RBYTES_W'(div_trial - {1'b0, rbytes_reg})
                                   : RBYTES_W'(div_trial);
                dq_next   = {dq_reg[OFFSET_W-2:0], div_ge};
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = ST_FREE_CHK;
                end
            end

            ST_FREE_CHK:
            begin
                if (dq_reg >= OFFSET_W'(total_reg) || dq_reg >= OFFSET_W'(MAX_RECORDS))
                begin
                    status_next = STAT_BADFREE;
                end
                else
                begin
                    bm_we    = 1'b1;
                    bm_waddr = BW'(dq_reg);
                    bm_wdata = 1'b1;
                end
                state_next = ST_DONE;
            end

            ST_RC_ISSUE:
            begin
                if (idx_reg == seg_n)
                begin
                    if (!after_alloc_reg)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (cnt_reg != '0)
                    begin
                        state_next = ST_POP;
                    end
                    else
                    begin
                        status_next = STAT_NOSPACE;
                        state_next  = ST_DONE;
                    end
                end
                else if (!g_rc_ok)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_RC_CHECK;
                end
            end

            ST_RC_CHECK:
            begin
                if (bm_rdata[0])
                begin
                    bm_we     = 1'b1;
                    harv_next = harv_reg + CW'(1);
                    if (cnt_reg < CW'(MAX_PER_HOST))
                    begin
                        st_we    = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
                idx_next   = idx_reg + CW'(1);
                state_next = ST_RC_ISSUE;
            end

            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_off_next   = res_off_reg;
                    out_stat_next  = status_reg;
                    out_harv_next  = harv_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    bbra_ram #(
        .WIDTH (SW),
        .DEPTH (MAX_PER_HOST)
    ) u_stack (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    bbra_ram #(
        .WIDTH (1),
        .DEPTH (MAX_RECORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    // The free stack never holds more than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_PER_HOST))
    else $error("free stack count beyond depth");

    // An accepted beat always starts with the segment base product.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> state_reg == ST_SEG_MUL)
    else $error("accepted beat did not start the sequence");

    // A failed allocation never reports a nonzero offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_NOSPACE) |-> alloc_offset == '0)
    else $error("out-of-space result with nonzero offset");

    // A pop only starts with a nonempty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> cnt_reg != '0)
    else $error("pop from empty free stack");

    // Every result beat is loaded only from the finishing step.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == ST_DONE)
    else $error("result raised outside the finishing step");

endmodule

[verif/tb_bump_bitmap_record_allocator.sv]
// Self-checking testbench for the bump/bitmap record allocator.
// Depends on bbra_pkg and the bump_bitmap_record_allocator RTL only.
`timescale 1ns / 1ps

// One expected result beat.
typedef struct {
    logic [47:0] offset;
    logic [1:0]  stat;
    logic [12:0] harv;
} alloc_result_t;

// Scoreboard: it carries its own copy of the allocator state and the
// registers, works out the result of every accepted input beat and holds
// those results in order until the block returns them.
class alloc_scoreboard;
    logic [2:0]    host;
    logic [12:0]   per_host;
    logic [15:0]   total;
    logic [12:0]   rec_bytes;
    logic [39:0]   base;
    int            cursor;
    logic [11:0]   stack[4096];
    int            stack_count;
    bit            freed[32768];
    alloc_result_t pending_q[$];
    int            errors;
    int            checked;
    int            n_nospace;
    int            n_badfree;
    int            n_harvest;

    function new();
        host = 0;
        per_host = 4096;
        total = 32768;
        rec_bytes = 16;
        base = 0;
        cursor = 0;
        stack_count = 0;
        errors = 0;
        checked = 0;
        n_nospace = 0;
        n_badfree = 0;
        n_harvest = 0;
        foreach (freed[i]) freed[i] = 0;
    endfunction

    function int seg_records();
        return (per_host > 4096) ? 4096 : int'(per_host);
    endfunction

    function logic [47:0] record_offset(int idx);
        logic [63:0] g;
        g = 64'(host) * 64'(seg_records()) + 64'(idx);
        return 48'(64'(base) + g * 64'(rec_bytes));
    endfunction

    function int sweep_segment();
        int n;
        int cnt;
        int g;
        n = seg_records();
        cnt = 0;
        for (int i = 0; i < n; i++)
        begin
            g = int'(host) * n + i;
            if (g < 32768 && freed[g])
            begin
                freed[g] = 0;
                cnt++;
                if (stack_count < 4096)
                begin
                    stack[stack_count] = 12'(i);
                    stack_count++;
                end
            end
        end
        return cnt;
    endfunction

    function void write_reg(logic [2:0] idx, logic [39:0] data);
        case (idx)
            bbra_pkg::CFG_HOST_INDEX:   host = data[2:0];
            bbra_pkg::CFG_RECS_PER_HST: per_host = data[12:0];
            bbra_pkg::CFG_TOTAL_RECS:   total = data[15:0];
            bbra_pkg::CFG_RECORD_BYTES: rec_bytes = data[12:0];
            bbra_pkg::CFG_RECORDS_BASE: base = data;
            default: ;
        endcase
    endfunction

    function void note_input(logic [1:0] op, logic [47:0] off);
        alloc_result_t r;
        logic [63:0]   rec;
        int            n;
        r.offset = 0;
        r.stat = bbra_pkg::STAT_DONE;
        r.harv = 0;
        n = seg_records();
        if (op == bbra_pkg::OP_ALLOC)
        begin
            if (stack_count > 0)
            begin
                stack_count--;
                r.offset = record_offset(int'(stack[stack_count]));
            end
            else if (cursor < n)
            begin
                r.offset = record_offset(cursor);
                cursor++;
            end
            else
            begin
                cursor = n;
                r.harv = 13'(sweep_segment());
                if (stack_count > 0)
                begin
                    stack_count--;
                    r.offset = record_offset(int'(stack[stack_count]));
                end
                else
                    r.stat = bbra_pkg::STAT_NOSPACE;
            end
        end
        else if (op == bbra_pkg::OP_FREE)
        begin
            if (off < 48'(base) || rec_bytes == 0)
                r.stat = bbra_pkg::STAT_BADFREE;
            else
            begin
                rec = 64'(off - 48'(base)) / 64'(rec_bytes);
                if (rec >= 64'(total) || rec >= 64'd32768)
                    r.stat = bbra_pkg::STAT_BADFREE;
                else
                    freed[rec[14:0]] = 1;
            end
        end
        else if (op == bbra_pkg::OP_RECLAIM)
            r.harv = 13'(sweep_segment());
        pending_q.insert(pending_q.size(), r);
    endfunction

    function void check_result(logic [47:0] offset, logic [1:0] stat, logic [12:0] harv);
        alloc_result_t r;
        if (pending_q.size() == 0)
        begin
            $display("%0t: result beat with nothing expected (offset %h status %0d)",
                     $time, offset, stat);
            errors++;
            return;
        end
        r = pending_q.pop_front();
        checked++;
        if (stat == bbra_pkg::STAT_NOSPACE) n_nospace++;
        if (stat == bbra_pkg::STAT_BADFREE) n_badfree++;
        if (harv != 0) n_harvest++;
        if (offset !== r.offset)
        begin
            $display("%0t: alloc_offset expected %h actual %h", $time, r.offset, offset);
            errors++;
        end
        if (stat !== r.stat)
        begin
            $display("%0t: status expected %0d actual %0d", $time, r.stat, stat);
            errors++;
        end
        if (harv !== r.harv)
        begin
            $display("%0t: harvested expected %0d actual %0d", $time, r.harv, harv);
            errors++;
        end
    endfunction
endclass

module tb_bump_bitmap_record_allocator;
    import bbra_pkg::*;

    // Slowest case is a reclaim of a full 4096-record segment; the few phases
    // with large segments dominate. The bitmap sweep after reset adds to the
    // run time.
    localparam int CYCLE_LIMIT = 4000000;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 in_valid = 0;
    logic                 in_stall;
    logic [1:0]           opcode = 0;
    logic [OFFSET_W-1:0]  free_offset = 0;
    logic                 out_valid;
    logic                 out_stall = 0;
    logic [OFFSET_W-1:0]  alloc_offset;
    logic [1:0]           status;
    logic [HARV_W-1:0]    harvested;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = 0;
    logic [BASE_W-1:0]    cfg_data = 0;

    alloc_scoreboard sb = new();
    int cycles = 0;
    int idle_pct = 0;
    int stall_pct = 0;
    int beats_sent = 0;

    bump_bitmap_record_allocator DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .free_offset(free_offset),
        .out_valid(out_valid), .out_stall(out_stall),
        .alloc_offset(alloc_offset), .status(status), .harvested(harvested),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // The watchdog counts cycles and ends a run that has hung.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side. Values read right after the edge are the ones the block
    // held before it, so a beat is taken when valid was high and our stall
    // was low. The stall for the next edge is then drawn at random.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(alloc_offset, status, harvested);
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Sends one input beat. An idle gap, if one is drawn, lowers valid first;
    // otherwise valid simply stays high from the previous beat, so the signal
    // sees only one assignment per edge.
    task automatic send_beat(logic [1:0] op, logic [47:0] off);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        in_valid <= 1;
        opcode <= op;
        free_offset <= off;
        do @(posedge clk); while (in_stall);
        sb.note_input(op, off);
        beats_sent++;
    endtask

    // Waits until every expected result has come back, then lets the block
    // settle before the next register write.
    task automatic drain();
        in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [39:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic configure(int h, int rph, int tot, int rb, logic [39:0] b);
        drain();
        write_reg(CFG_HOST_INDEX, 40'(h));
        write_reg(CFG_RECS_PER_HST, 40'(rph));
        write_reg(CFG_TOTAL_RECS, 40'(tot));
        write_reg(CFG_RECORD_BYTES, 40'(rb));
        write_reg(CFG_RECORDS_BASE, b);
    endtask

    function automatic logic [47:0] rand48();
        return 48'({$urandom, $urandom} >> 16);
    endfunction

    // A free offset that mostly lands in this host's segment, with a random
    // byte inside the record so that truncation is exercised.
    function automatic logic [47:0] pick_free_offset();
        int    sel;
        int    seg;
        logic [63:0] g;
        logic [63:0] o;
        sel = $urandom_range(99);
        seg = sb.seg_records();
        if (sel < 8)
            return rand48();
        if (sel < 12)
            return 48'(sb.base) - 48'($urandom_range(1, 64));
        if (sel < 75 && seg > 0)
            g = 64'(sb.host) * 64'(seg) + 64'($urandom_range(seg - 1));
        else
            g = 64'($urandom_range(32900));
        o = 64'(sb.base) + g * 64'(sb.rec_bytes);
        if (sb.rec_bytes > 1)
            o = o + 64'($urandom_range(int'(sb.rec_bytes) - 1));
        return 48'(o);
    endfunction

    task automatic random_beats(int n);
        int sel;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                send_beat(OP_ALLOC, rand48());
            else if (sel < 82)
                send_beat(OP_FREE, pick_free_offset());
            else if (sel < 96)
                send_beat(OP_RECLAIM, rand48());
            else
                send_beat(OP_UNUSED, rand48());
        end
    endtask

    task automatic set_idling(int mode);
        case (mode % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 58; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 58; end
            default: begin idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    initial
    begin
        logic [47:0] a0;
        logic [47:0] a1;
        int          h;
        int          rph;
        int          tot;
        int          rb;
        logic [39:0] b;

        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part at the reset settings: bump allocates, frees of
        // those records, bad frees, a reclaim, a pop and the unused opcode.
        send_beat(OP_ALLOC, '0);
        send_beat(OP_ALLOC, '1);
        a0 = sb.record_offset(0);
        a1 = sb.record_offset(1) + 48'd5;
        send_beat(OP_FREE, a0);
        send_beat(OP_FREE, a1);
        send_beat(OP_FREE, '1);
        send_beat(OP_FREE, 48'd524288);
        send_beat(OP_RECLAIM, '0);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_UNUSED, '1);
        send_beat(OP_RECLAIM, '0);

        // One-record segment at the top host and largest base: exhaustion
        // with nothing to reclaim, then exhaustion that reclaims and pops.
        configure(7, 1, 32768, 4096, 40'hFF_FFFF_FFFF);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_FREE, sb.record_offset(0) + 48'd4095);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_FREE, 48'd100);
        // Zero record size and an empty segment.
        configure(2, 0, 1, 0, 40'd0);
        send_beat(OP_FREE, 48'd0);
        send_beat(OP_ALLOC, '0);
        send_beat(OP_RECLAIM, '0);
        configure(0, 8191, 65535, 1, 40'd3);
        send_beat(OP_FREE, 48'd3);
        send_beat(OP_FREE, 48'd2);
        send_beat(OP_FREE, 48'd32770);
        send_beat(OP_RECLAIM, '0);

        // Deep free stack: the same record freed and reclaimed over and over
        // piles duplicates onto the stack, then an allocate pops one.
        configure(1, 1, 32768, 1, 40'd0);
        for (int k = 0; k < 120; k++)
        begin
            send_beat(OP_FREE, 48'd1);
            send_beat(OP_RECLAIM, '0);
        end
        send_beat(OP_ALLOC, '0);

        // Random phases over many settings. Segments stay small so that the
        // cursor runs out; two phases use the full segment with few beats.
        for (int p = 0; p < 12; p++)
        begin
            h = $urandom_range(7);
            rph = (p % 5 == 4) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(3))
                0: tot = 1;
                1: tot = 32768;
                2: tot = 65535;
                default: tot = $urandom_range(1, 40000);
            endcase
            case ($urandom_range(3))
                0: rb = 1;
                1: rb = 4096;
                default: rb = $urandom_range(1, 8191);
            endcase
            case ($urandom_range(2))
                0: b = 40'd0;
                1: b = 40'hFF_FFFF_FFFF;
                default: b = 40'({$urandom, $urandom} >> 24);
            endcase
            if (p == 3 || p == 9)
                rph = 4096;
            configure(h, rph, tot, rb, b);
            set_idling(p);
            random_beats((rph == 4096) ? 30 : 150);
        end
        drain();

        $display("Sent %0d input beats, checked %0d results over 17 register settings.",
                 beats_sent, sb.checked);
        $display("Seen: %0d out-of-space, %0d rejected frees, %0d nonzero reclaim counts.",
                 sb.n_nospace, sb.n_badfree, sb.n_harvest);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[bump_bitmap_record_allocator.f]
rtl/core/bbra_pkg.sv
rtl/core/bbra_ram.sv
rtl/core/bump_bitmap_record_allocator.sv
verif/tb_bump_bitmap_record_allocator.sv
